// ===== rtl/hta_pkg.sv =====
package hta_pkg;

   localparam int TABLE_DEPTH  = 256;
   localparam int DATA_WIDTH   = 32;
   localparam int HANDLE_SPACE = 256;
   localparam int HANDLE_LIMIT = (TABLE_DEPTH < HANDLE_SPACE) ? TABLE_DEPTH : HANDLE_SPACE;
   localparam int HANDLE_WIDTH = 8;
   localparam int WORD_WIDTH   = 32;
   localparam int COUNT_WIDTH  = 9;

   typedef logic [1:0]              req_kind_type;
   typedef logic [1:0]              status_type;
   typedef logic [HANDLE_WIDTH-1:0] handle_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [DATA_WIDTH-1:0]   data_type;
   typedef logic [WORD_WIDTH-1:0]   word_type;

   localparam req_kind_type REQ_ALLOC = 2'd0;
   localparam req_kind_type REQ_FREE  = 2'd1;
   localparam req_kind_type REQ_GET   = 2'd2;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_INVALID = 2'd1;
   localparam status_type ST_FULL    = 2'd2;

   localparam count_type LIMIT_COUNT = COUNT_WIDTH'(HANDLE_LIMIT);
   localparam count_type SPACE_COUNT = COUNT_WIDTH'(HANDLE_SPACE);

   typedef struct packed {
      logic       push;
      logic       pop;
      handle_type handle;
   } stack_op_type;

   typedef struct packed {
      logic       wr_en;
      handle_type wr_handle;
      data_type   wr_data;
      logic       clr_en;
      handle_type clr_handle;
      logic       rd_en;
      handle_type rd_handle;
   } table_op_type;

endpackage

// ===== rtl/hta_channels.sv =====
interface hta_req_if;
   import hta_pkg::*;

   logic         valid;
   logic         ready;
   req_kind_type req_type;
   handle_type   handle_in;
   word_type     data_in;

   modport source (output valid, req_type, handle_in, data_in, input ready);
   modport sink (input valid, req_type, handle_in, data_in, output ready);
endinterface

interface hta_rsp_if;
   import hta_pkg::*;

   logic       valid;
   logic       ready;
   handle_type handle_out;
   word_type   data_out;
   status_type status;

   modport source (output valid, handle_out, data_out, status, input ready);
   modport sink (input valid, handle_out, data_out, status, output ready);
endinterface

// ===== rtl/hta_free_stack.sv =====
module hta_free_stack (
   input  logic                  clock,
   input  logic                  reset,
   input  hta_pkg::stack_op_type op,
   output hta_pkg::handle_type   top,
   output hta_pkg::count_type    count
);
   import hta_pkg::*;

   // Top two entries live in flops; the RAM read runs one entry further down
   // so a pop can refill the second slot without waiting on the read.
   handle_type stack_mem [HANDLE_SPACE];
   count_type  count_ff, count_in;
   handle_type top_ff, top_in;
   handle_type second_ff, second_in;
   handle_type third_ff;
   handle_type rd_addr;

   always_comb begin
      count_in  = count_ff;
      top_in    = top_ff;
      second_in = second_ff;
      if (op.push) begin
         count_in  = count_ff + 1'b1;
         top_in    = op.handle;
         second_in = top_ff;
      end else if (op.pop) begin
         count_in  = count_ff - 1'b1;
         top_in    = second_ff;
         second_in = third_ff;
      end
      rd_addr = count_in[HANDLE_WIDTH-1:0] - HANDLE_WIDTH'(3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff    <= top_in;
      second_ff <= second_in;
   end

   always_ff @(posedge clock) begin
      if (op.push) begin
         stack_mem[count_ff[HANDLE_WIDTH-1:0]] <= op.handle;
      end
      third_ff <= stack_mem[rd_addr];
   end

   assign top   = top_ff;
   assign count = count_ff;

endmodule

// ===== rtl/hta_entry_store.sv =====
module hta_entry_store (
   input  logic                  clock,
   input  logic                  reset,
   input  hta_pkg::table_op_type op,
   input  hta_pkg::handle_type   look_handle,
   output logic                  look_valid,
   output hta_pkg::data_type     rd_data
);
   import hta_pkg::*;

   data_type                  entry_mem [HANDLE_SPACE];
   logic [HANDLE_SPACE-1:0]   valid_ff, valid_in;
   data_type                  rd_ff;

   always_comb begin
      valid_in = valid_ff;
      if (op.clr_en) begin
         valid_in[op.clr_handle] = 1'b0;
      end
      if (op.wr_en) begin
         valid_in[op.wr_handle] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op.wr_en) begin
         entry_mem[op.wr_handle] <= op.wr_data;
      end
      if (op.rd_en) begin
         rd_ff <= entry_mem[op.rd_handle];
      end
   end

   assign look_valid = valid_ff[look_handle];
   assign rd_data    = rd_ff;

endmodule

// ===== rtl/handle_table_allocator_core.sv =====
// Handle table with a LIFO free list.
// Requests arrive on req_chan (valid/ready): req_type selects allocate, free
// or get; handle_in names the handle for free and get; data_in is the word
// stored on allocate. Each request yields exactly one response on rsp_chan
// with handle_out (new handle on allocate), data_out (stored word on get)
// and status (ok, invalid handle, table full), in request order.
// Allocate reuses the most recently freed handle first, else a fresh handle
// counting up from 1; handle 0 is never issued.
// The response is registered in stage p1, then in the rsp stage.
// Throughput: one request per cycle while rsp_chan is not stalled. Each
// request makes one access to the entry RAM and the top of the free stack,
// whose top two entries sit in flops in front of the stack RAM.
// The block holds up to two requests in flight: when rsp_chan is stalled it
// still takes one more request, then drops req_chan.ready until the
// response is taken.
// Reset (synchronous) marks all handles free, empties the stack, restarts
// fresh handles at 1 and clears both pipeline stages; no clearing pass.
module handle_table_allocator_core (
   input logic       clock,
   input logic       reset,
   hta_req_if.sink   req_chan,
   hta_rsp_if.source rsp_chan
);
   import hta_pkg::*;

   stack_op_type stack_op;
   table_op_type table_op;
   handle_type   stack_top;
   count_type    stack_count;
   logic         look_valid;
   data_type     rd_data;

   count_type  fresh_ff, fresh_in;
   logic       p1_valid_ff;
   handle_type p1_handle_ff;
   status_type p1_status_ff;
   logic       p1_get_ok_ff;
   logic       rsp_valid_ff;
   handle_type rsp_handle_ff;
   word_type   rsp_data_ff;
   status_type rsp_status_ff;

   logic       accept;
   logic       p1_adv;
   logic       live;
   logic       got;
   logic       take_fresh;
   logic       get_ok;
   handle_type slot;
   handle_type res_handle;
   status_type res_status;

   hta_free_stack u_stack (
      .clock (clock),
      .reset (reset),
      .op    (stack_op),
      .top   (stack_top),
      .count (stack_count)
   );

   hta_entry_store u_store (
      .clock       (clock),
      .reset       (reset),
      .op          (table_op),
      .look_handle (req_chan.handle_in),
      .look_valid  (look_valid),
      .rd_data     (rd_data)
   );

   assign p1_adv         = p1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !p1_valid_ff || p1_adv;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      live = (req_chan.handle_in != '0)
          && ({1'b0, req_chan.handle_in} < fresh_ff)
          && ({1'b0, req_chan.handle_in} < LIMIT_COUNT)
          && look_valid;

      got        = 1'b0;
      take_fresh = 1'b0;
      get_ok     = 1'b0;
      slot       = '0;
      res_handle = '0;
      res_status = ST_OK;
      stack_op   = '0;
      table_op   = '0;

      case (req_chan.req_type)
         REQ_ALLOC: begin
            if (stack_count != '0) begin
               slot        = stack_top;
               got         = 1'b1;
               stack_op.pop = accept;
            end else if (fresh_ff < LIMIT_COUNT) begin
               slot       = fresh_ff[HANDLE_WIDTH-1:0];
               got        = 1'b1;
               take_fresh = 1'b1;
            end else begin
               res_status = ST_FULL;
            end
            if (got) begin
               res_handle         = slot;
               table_op.wr_en     = accept;
               table_op.wr_handle = slot;
            end
         end
         REQ_FREE: begin
            if (live && (stack_count < SPACE_COUNT)) begin
               stack_op.push       = accept;
               table_op.clr_en     = accept;
            end else begin
               res_status = ST_INVALID;
            end
         end
         REQ_GET: begin
            if (live) begin
               get_ok         = 1'b1;
               table_op.rd_en = accept;
            end else begin
               res_status = ST_INVALID;
            end
         end
         default: begin
         end
      endcase

      stack_op.handle     = req_chan.handle_in;
      table_op.clr_handle = req_chan.handle_in;
      table_op.rd_handle  = req_chan.handle_in;
      table_op.wr_data    = req_chan.data_in[DATA_WIDTH-1:0];

      fresh_in = fresh_ff;
      if (accept && take_fresh) begin
         fresh_in = fresh_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff     <= COUNT_WIDTH'(1);
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fresh_ff     <= fresh_in;
         p1_valid_ff  <= accept || (p1_valid_ff && !p1_adv);
         rsp_valid_ff <= p1_adv || (rsp_valid_ff && !rsp_chan.ready);
      end
   end

   // Hold stage payloads while the next stage is stalled.
   always_ff @(posedge clock) begin
      if (accept) begin
         p1_handle_ff <= res_handle;
         p1_status_ff <= res_status;
         p1_get_ok_ff <= get_ok;
      end
      if (p1_adv) begin
         rsp_handle_ff <= p1_handle_ff;
         rsp_status_ff <= p1_status_ff;
         rsp_data_ff   <= p1_get_ok_ff ? WORD_WIDTH'(rd_data) : '0;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.handle_out = rsp_handle_ff;
   assign rsp_chan.data_out   = rsp_data_ff;
   assign rsp_chan.status     = rsp_status_ff;

endmodule

// ===== rtl/hta_checker.sv =====
module hta_checker (
   input logic       clock,
   input logic       reset,
   hta_req_if.sink   req_chan,
   hta_rsp_if.source rsp_chan
);
   import hta_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=>
         rsp_chan.valid && $stable(rsp_chan.handle_out)
         && $stable(rsp_chan.data_out) && $stable(rsp_chan.status))
      else $error("response changed while stalled");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status != ST_OK) |->
         (rsp_chan.handle_out == '0) && (rsp_chan.data_out == '0))
      else $error("failed request returned nonzero fields");

   a_alloc_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.handle_out != '0) |->
         (rsp_chan.status == ST_OK) && (rsp_chan.data_out == '0))
      else $error("allocate response carries data or error");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         (rsp_chan.status == ST_OK) || (rsp_chan.status == ST_INVALID)
         || (rsp_chan.status == ST_FULL))
      else $error("unknown status code");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && req_chan.ready)
      else $error("pipeline not empty after reset");

endmodule

bind handle_table_allocator_core hta_checker u_hta_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
